// ----- hdl/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// Touch qualifier package
// Types and fixed constants shared by the touch tap and swipe qualifier.
// ----------------------------------------------------------------------------
package tts_pkg;

    typedef enum logic [1:0] {
        EV_TAP     = 2'd0,
        EV_SWIPE   = 2'd1,
        EV_DROPPED = 2'd2
    } event_kind_t;

    localparam logic [1:0] PC_NONE = 2'b00;
    localparam logic [1:0] PC_ONE  = 2'b01;

    localparam logic [1:0] CFG_TAP_SLOP       = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_POLLS = 2'd1;
    localparam logic [1:0] CFG_MIN_TRUSTED    = 2'd2;
    localparam logic [1:0] CFG_GRACE_POLLS    = 2'd3;

    localparam logic [7:0]  TAP_SLOP_RST       = 8'd24;
    localparam logic [3:0]  DEBOUNCE_POLLS_RST = 4'd2;
    localparam logic [15:0] MIN_TRUSTED_RST    = 16'd1;
    localparam logic [7:0]  GRACE_POLLS_RST    = 8'd40;

    localparam logic [15:0] RAW_X_MAX = 16'd800;
    localparam logic [15:0] RAW_Y_MAX = 16'd480;
    localparam logic [8:0]  SCR_Y_MAX = 9'd479;

    // Numerators are divided by 32 first, then by 25 (x) or 15 (y) through
    // a reciprocal multiply that is exact over the whole numerator range.
    localparam logic [18:0] X_SCALE = 19'd479;
    localparam logic [18:0] X_ROUND = 19'd400;
    localparam logic [18:0] Y_SCALE = 19'd799;
    localparam logic [18:0] Y_ROUND = 19'd240;
    localparam logic [26:0] X_RECIP = 27'd5243;
    localparam logic [28:0] Y_RECIP = 29'd17477;

endpackage

// ----- hdl/touch_tap_swipe_qualifier.sv -----
// ----------------------------------------------------------------------------
// Touch tap and swipe qualifier
// Qualifies touch controller polls into tap, swipe and dropped-tap events.
//
//  Channel  Prefix  Direction  Beat
//  poll     s_      in         one controller poll
//  event    m_      out        one tap, swipe or dropped tap
//  config   cfg_    in         one register write, no handshake
//
// A poll is taken into an input register, where the coordinate numerators
// are also formed, and is qualified from there into the state and the
// output register. One poll can be accepted every cycle; the only stall is an
// event held in the output register with m_ready low while the input
// register is full. Synchronous reset clears the valid flags and touch state.
// ----------------------------------------------------------------------------
module touch_tap_swipe_qualifier
    import tts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [1:0]  s_point_count,
    input  logic [15:0]        s_raw_x,
    input  logic [15:0]        s_raw_y,
    input  logic [15:0]        s_contact_size,
    input  logic               s_locked,
    input  logic [31:0]        s_card_gen,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_event_kind,
    output logic [9:0]         m_start_x,
    output logic [8:0]         m_start_y,
    output logic [9:0]         m_end_x,
    output logic [8:0]         m_end_y,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    logic [7:0]  tap_slop_reg;
    logic [3:0]  debounce_reg;
    logic [15:0] min_trusted_reg;
    logic [7:0]  grace_reg;

    logic        s1_valid_reg;
    logic [1:0]  s1_pc_reg;
    logic [13:0] s1_vx_reg;
    logic [13:0] s1_vy_reg;
    logic [15:0] s1_size_reg;
    logic        s1_locked_reg;
    logic [31:0] s1_gen_reg;

    logic        touching_reg, touching_next;
    logic [3:0]  streak_reg, streak_next;
    logic [9:0]  down_x_reg, down_x_next;
    logic [8:0]  down_y_reg, down_y_next;
    logic [9:0]  latest_x_reg, latest_x_next;
    logic [8:0]  latest_y_reg, latest_y_next;
    logic [31:0] gen_reg, gen_next;
    logic [7:0]  polls_reg, polls_next;

    logic        m_valid_reg;
    event_kind_t ev_kind_reg, ev_kind_next;

    logic [9:0]  m_start_x_reg;
    logic [8:0]  m_start_y_reg;
    logic [9:0]  m_end_x_reg;
    logic [8:0]  m_end_y_reg;

    logic        adv;
    logic        produce;
    logic        believed;
    logic        grace_active;
    logic [3:0]  streak_inc;

    logic [9:0]  cx;
    logic [8:0]  cy;
    logic [8:0]  dist_y;
    logic [18:0] num_x;
    logic [18:0] num_y;
    logic [26:0] prod_x;
    logic [28:0] prod_y;
    logic [8:0]  px;
    logic [9:0]  map_x;
    logic [8:0]  map_y;
    logic [9:0]  diff_x;
    logic [8:0]  diff_y;

    assign adv     = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || adv;

    // Input side: clamp and form the rounded numerators divided by 32.
    always_comb begin
        cx     = (s_raw_x > RAW_X_MAX) ? RAW_X_MAX[9:0] : s_raw_x[9:0];
        cy     = (s_raw_y > RAW_Y_MAX) ? RAW_Y_MAX[8:0] : s_raw_y[8:0];
        dist_y = RAW_Y_MAX[8:0] - cy;
        num_x  = {9'd0, cx} * X_SCALE + X_ROUND;
        num_y  = {10'd0, dist_y} * Y_SCALE + Y_ROUND;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_pc_reg     <= s_point_count;
            s1_vx_reg     <= num_x[18:5];
            s1_vy_reg     <= num_y[18:5];
            s1_size_reg   <= s_contact_size;
            s1_locked_reg <= s_locked;
            s1_gen_reg    <= s_card_gen;
        end
    end

    // Qualify side: finish the scaling and update the touch state.
    always_comb begin
        prod_x = {13'd0, s1_vx_reg} * X_RECIP;
        prod_y = {15'd0, s1_vy_reg} * Y_RECIP;
        px     = prod_x[25:17];
        map_x  = prod_y[27:18];
        map_y  = SCR_Y_MAX - px;
        diff_x = (latest_x_reg > down_x_reg) ? (latest_x_reg - down_x_reg)
                                             : (down_x_reg - latest_x_reg);
        diff_y = (latest_y_reg > down_y_reg) ? (latest_y_reg - down_y_reg)
                                             : (down_y_reg - latest_y_reg);
    end

    always_comb begin
        touching_next = touching_reg;
        streak_next   = streak_reg;
        down_x_next   = down_x_reg;
        down_y_next   = down_y_reg;
        latest_x_next = latest_x_reg;
        latest_y_next = latest_y_reg;
        gen_next      = gen_reg;
        polls_next    = polls_reg;
        produce       = 1'b0;
        believed      = 1'b0;
        ev_kind_next  = EV_TAP;
        grace_active  = polls_reg < grace_reg;
        streak_inc    = (streak_reg == 4'hF) ? streak_reg : streak_reg + 4'd1;

        if (diff_x > {2'd0, tap_slop_reg} || diff_y > {1'b0, tap_slop_reg}) begin
            ev_kind_next = EV_SWIPE;
        end else if (s1_gen_reg != gen_reg) begin
            ev_kind_next = EV_DROPPED;
        end

        if (adv) begin
            if (polls_reg != 8'hFF) begin
                polls_next = polls_reg + 8'd1;
            end
            priority if (s1_locked_reg) begin
                touching_next = 1'b0;
                streak_next   = 4'd0;
            end else if (s1_pc_reg == PC_ONE) begin
                if (grace_active) begin
                    touching_next = 1'b0;
                    streak_next   = 4'd0;
                end else begin
                    if (s1_size_reg >= min_trusted_reg) begin
                        believed = 1'b1;
                    end else begin
                        streak_next = streak_inc;
                        believed    = streak_inc >= debounce_reg;
                    end
                    if (believed) begin
                        latest_x_next = map_x;
                        latest_y_next = map_y;
                        if (!touching_reg) begin
                            down_x_next = map_x;
                            down_y_next = map_y;
                            gen_next    = s1_gen_reg;
                        end
                        touching_next = 1'b1;
                    end
                end
            end else if (s1_pc_reg == PC_NONE) begin
                produce       = touching_reg;
                touching_next = 1'b0;
                streak_next   = 4'd0;
            end else begin
                touching_next = 1'b0;
                streak_next   = 4'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touching_reg    <= 1'b0;
            streak_reg      <= 4'd0;
            down_x_reg      <= 10'd0;
            down_y_reg      <= 9'd0;
            latest_x_reg    <= 10'd0;
            latest_y_reg    <= 9'd0;
            gen_reg         <= 32'd0;
            polls_reg       <= 8'd0;
            m_valid_reg     <= 1'b0;
            tap_slop_reg    <= TAP_SLOP_RST;
            debounce_reg    <= DEBOUNCE_POLLS_RST;
            min_trusted_reg <= MIN_TRUSTED_RST;
            grace_reg       <= GRACE_POLLS_RST;
        end else begin
            touching_reg <= touching_next;
            streak_reg   <= streak_next;
            down_x_reg   <= down_x_next;
            down_y_reg   <= down_y_next;
            latest_x_reg <= latest_x_next;
            latest_y_reg <= latest_y_next;
            gen_reg      <= gen_next;
            polls_reg    <= polls_next;
            if (produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TAP_SLOP:       tap_slop_reg    <= cfg_wdata[7:0];
                    CFG_DEBOUNCE_POLLS: debounce_reg    <= cfg_wdata[3:0];
                    CFG_MIN_TRUSTED:    min_trusted_reg <= cfg_wdata;
                    CFG_GRACE_POLLS:    grace_reg       <= cfg_wdata[7:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            ev_kind_reg   <= ev_kind_next;
            m_start_x_reg <= down_x_reg;
            m_start_y_reg <= down_y_reg;
            m_end_x_reg   <= latest_x_reg;
            m_end_y_reg   <= latest_y_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = ev_kind_reg;
    assign m_start_x    = m_start_x_reg;
    assign m_start_y    = m_start_y_reg;
    assign m_end_x      = m_end_x_reg;
    assign m_end_y      = m_end_y_reg;

    // An event appears only after a lift poll seen while touching.
    a_event_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |->
            ($past(adv) && $past(touching_reg) && $past(s1_pc_reg) == PC_NONE
             && !$past(s1_locked_reg)))
        else $error("event without a qualified lift");

    // A locked poll always ends the touch.
    a_lock_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s1_locked_reg) |=> (!touching_reg && streak_reg == 4'd0))
        else $error("locked poll left touch state set");

    // The pipeline never drops an unconsumed event.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        produce |-> (!m_valid_reg || m_ready))
        else $error("event overwritten while stalled");

endmodule
